FILE: design/wpbq_pkg.sv
// ----------------------------------------------------------------------------
// wpbq_pkg
// Shared types and constants for the waveform peak builder and query block.
// ----------------------------------------------------------------------------
`default_nettype none

package wpbq_pkg;

  localparam int unsigned CH_W     = 3;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned POS_W    = 21;
  localparam int unsigned NCH_W    = 4;
  localparam int unsigned CFG_W    = 21;
  localparam int unsigned TDATA_W  = 64;
  localparam int unsigned ODATA_W  = 32;

  // Bucket size is a power of two so that bucket indexes are plain shifts.
  localparam int unsigned BUCKET_SH          = 8;
  localparam int unsigned SAMPLES_PER_BUCKET = 32'd1 << BUCKET_SH;

  localparam logic signed [SAMPLE_W-1:0] PEAK_POS = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] PEAK_NEG = -16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] CODE_MIN = -16'sd32768;

  localparam logic [POS_W-1:0] TOTAL_RESET = 21'd1048576;
  localparam logic [NCH_W-1:0] NCH_RESET   = 4'd1;

  typedef enum logic {
    REG_NUM_CHANNELS  = 1'b0,
    REG_TOTAL_SAMPLES = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN,
    ST_OUT
  } back_state_e;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic                       is_query;
    logic                       ch_ok;
    logic                       early_empty;
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0]           start_s;
    logic [POS_W-1:0]           end_s;
  } item_t;

endpackage

`default_nettype wire

FILE: design/waveform_peak_builder_and_query.sv
// ----------------------------------------------------------------------------
// waveform_peak_builder_and_query
// Min/max peak decimation of audio with bucket range queries.
// ----------------------------------------------------------------------------
// Channel   Direction  tdata / tuser contents
// s_axis    in         tdata: channel[2:0] sample_value[18:3] start_sample[39:19]
//                      end_sample[60:40]; tuser: opcode
// m_axis    out        tdata: min_peak[15:0] max_peak[31:16]; tuser: range_empty
// cfg       in         cfg_idx_i 0 num_channels, 1 total_samples
//
// Pushes may stream back to back through the back while it is idle, once
// registered in the input queue. A query holds the back while it reads each
// covered bucket in turn through the single peak-store read port, then
// passes ST_FIN and ST_OUT before its result is registered and offered; an
// empty range goes from the back's take straight to ST_OUT.
// A stalled result holds the back, the two-entry queue fills, tready drops.
// Reset restores running peaks, positions and registers; the store is not
// cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module waveform_peak_builder_and_query import wpbq_pkg::*; #(
  parameter int unsigned MAX_CHANNELS       = 8,
  parameter int unsigned MAX_BUCKETS        = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // channel, sample_value, start_sample, end_sample from bit 0 up
  input  wire logic [TDATA_W-1:0] s_axis_tdata,
  // opcode
  input  wire logic               s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // min_peak, max_peak from bit 0 up
  output logic [ODATA_W-1:0]      m_axis_tdata,
  // range_empty
  output logic                    m_axis_tuser,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [CFG_W-1:0]   cfg_data_i
);

  logic [NCH_W-1:0] num_channels_q;
  logic [POS_W-1:0] total_samples_q;
  item_t            item;
  logic             item_valid, item_ready;

  // hold configuration; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_channels_q  <= NCH_RESET;
      total_samples_q <= TOTAL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_NUM_CHANNELS:  num_channels_q  <= cfg_data_i[NCH_W-1:0];
        REG_TOTAL_SAMPLES: total_samples_q <= cfg_data_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

  wpbq_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_o      (s_axis_tready),
    .channel_i       (s_axis_tdata[2:0]),
    .sample_i        (s_axis_tdata[18:3]),
    .start_i         (s_axis_tdata[39:19]),
    .end_i           (s_axis_tdata[60:40]),
    .opcode_i        (s_axis_tuser),
    .num_channels_i  (num_channels_q),
    .total_samples_i (total_samples_q),
    .item_o          (item),
    .item_valid_o    (item_valid),
    .item_ready_i    (item_ready)
  );

  wpbq_back #(
    .MAX_CHANNELS      (MAX_CHANNELS),
    .MAX_BUCKETS       (MAX_BUCKETS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .item_i          (item),
    .item_valid_i    (item_valid),
    .item_ready_o    (item_ready),
    .total_samples_i (total_samples_q),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_data_o      (m_axis_tdata),
    .out_empty_o     (m_axis_tuser)
  );

endmodule

`default_nettype wire

FILE: design/wpbq_front.sv
// ----------------------------------------------------------------------------
// wpbq_front
// Accepts stream items, decodes and clamps them, and queues them for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module wpbq_front import wpbq_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_tvalid_i,
  output logic                    s_tready_o,
  input  wire logic [CH_W-1:0]    channel_i,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  input  wire logic [POS_W-1:0]   start_i,
  input  wire logic [POS_W-1:0]   end_i,
  input  wire logic               opcode_i,
  input  wire logic [NCH_W-1:0]   num_channels_i,
  input  wire logic [POS_W-1:0]   total_samples_i,
  output item_t                   item_o,
  output logic                    item_valid_o,
  input  wire logic               item_ready_i
);

  item_t       fifo_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  item_t       cls;
  logic        push, pop;
  logic [POS_W-1:0] end_c, start_c;
  logic signed [SAMPLE_W-1:0] smp;

  always_comb begin
    smp   = $signed(sample_i);
    end_c = (end_i > total_samples_i) ? total_samples_i : end_i;
    start_c = (start_i > end_c) ? end_c : start_i;
    cls.is_query    = (opcode_i == OP_QUERY);
    cls.ch_ok       = (32'(channel_i) < 32'(num_channels_i)) &&
                      (32'(channel_i) < MAX_CHANNELS);
    cls.early_empty = !cls.ch_ok || (start_c >= end_c);
    cls.channel     = channel_i;
    cls.sample      = (smp == CODE_MIN) ? PEAK_NEG : smp;
    cls.start_s     = start_c;
    cls.end_s       = end_c;
  end

  assign s_tready_o   = (count_q != 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = fifo_q[rd_ptr_q];
  assign push         = s_tvalid_i && s_tready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

endmodule

`default_nettype wire

FILE: design/wpbq_back.sv
// ----------------------------------------------------------------------------
// wpbq_back
// Folds pushes into per-channel peaks and the peak store; walks it for queries.
// ----------------------------------------------------------------------------
`default_nettype none

module wpbq_back import wpbq_pkg::*; #(
  parameter int unsigned MAX_CHANNELS       = 8,
  parameter int unsigned MAX_BUCKETS        = 4096
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire item_t            item_i,
  input  wire logic             item_valid_i,
  output logic                  item_ready_o,
  input  wire logic [POS_W-1:0] total_samples_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [ODATA_W-1:0]    out_data_o,
  output logic                  out_empty_o
);

  localparam int unsigned CIW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned DEPTH = MAX_CHANNELS * MAX_BUCKETS;
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // per-channel running state
  logic signed [SAMPLE_W-1:0] rmin_q [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] rmax_q [MAX_CHANNELS];
  logic [POS_W-1:0]           pos_q  [MAX_CHANNELS];
  logic [BUCKET_SH-1:0]       cnt_q  [MAX_CHANNELS];
  logic [POS_W-1:0]           bkt_q  [MAX_CHANNELS];

  logic [ODATA_W-1:0] mem [DEPTH];
  logic [ODATA_W-1:0] rd_data_q;
  logic               rd_valid_q, rd_en;
  logic [AW-1:0]      rd_addr;

  back_state_e state_q, state_d;

  logic [CIW-1:0]   cix, qch_q;
  logic             take, live, close, full, mem_we;
  logic [AW-1:0]    wr_addr;
  logic signed [SAMPLE_W-1:0] cur_min, cur_max, nmin, nmax;
  logic [POS_W-1:0] pos;

  // query datapath
  logic [POS_W-1:0] walk_q, last_q;
  logic             empty_q;
  logic signed [SAMPLE_W-1:0] mn_q, mx_q;
  logic [POS_W-1:0] first_c, last_raw, last_c;
  logic             q_empty;
  logic             out_free;
  logic signed [SAMPLE_W-1:0] bmin, bmax;

  assign cix     = CIW'(item_i.channel);
  assign cur_min = rmin_q[cix];
  assign cur_max = rmax_q[cix];
  assign pos     = pos_q[cix];
  assign take    = item_valid_i && item_ready_o;
  assign live    = take && !item_i.is_query && item_i.ch_ok && (pos < total_samples_i);
  assign nmin    = (item_i.sample < cur_min) ? item_i.sample : cur_min;
  assign nmax    = (item_i.sample > cur_max) ? item_i.sample : cur_max;
  assign full    = ((BUCKET_SH+1)'(cnt_q[cix]) + (BUCKET_SH+1)'(1)) ==
                   (BUCKET_SH+1)'(SAMPLES_PER_BUCKET);
  assign close   = full || ((pos + POS_W'(1)) == total_samples_i);
  assign mem_we  = live && close && (32'(bkt_q[cix]) < MAX_BUCKETS);
  assign wr_addr = AW'(32'(cix) * MAX_BUCKETS + 32'(bkt_q[cix]));
  assign out_free = !out_valid_o || out_ready_i;

  // bucket bounds of the incoming query; end is exclusive
  assign first_c  = item_i.start_s >> BUCKET_SH;
  assign last_raw = (item_i.end_s - POS_W'(1)) >> BUCKET_SH;
  assign last_c   = (32'(last_raw) > MAX_BUCKETS - 1) ? POS_W'(MAX_BUCKETS - 1) : last_raw;
  assign q_empty  = item_i.early_empty || (first_c > last_c);

  always_comb begin
    state_d      = state_q;
    item_ready_o = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = AW'(32'(qch_q) * MAX_BUCKETS + 32'(walk_q));
    case (state_q)
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i && item_i.is_query) begin
          state_d = q_empty ? ST_OUT : ST_WALK;
        end
      end
      ST_WALK: begin
        rd_en = 1'b1;
        if (walk_q == last_q) state_d = ST_FIN;
      end
      ST_FIN: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_valid_q <= 1'b0;
      out_valid_o <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        rmin_q[i] <= PEAK_POS;
        rmax_q[i] <= PEAK_NEG;
        pos_q[i]  <= '0;
        cnt_q[i]  <= '0;
        bkt_q[i]  <= '0;
      end
    end else begin
      state_q    <= state_d;
      rd_valid_q <= rd_en;
      if (live) begin
        pos_q[cix] <= pos + POS_W'(1);
        if (full) begin
          cnt_q[cix] <= '0;
          bkt_q[cix] <= bkt_q[cix] + POS_W'(1);
        end else begin
          cnt_q[cix] <= cnt_q[cix] + BUCKET_SH'(1);
        end
        // close the bucket: reset the running pair only
        rmin_q[cix] <= close ? PEAK_POS : nmin;
        rmax_q[cix] <= close ? PEAK_NEG : nmax;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  assign bmin = $signed(rd_data_q[SAMPLE_W-1:0]);
  assign bmax = $signed(rd_data_q[ODATA_W-1:SAMPLE_W]);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= {nmax, nmin};
    if (rd_en)  rd_data_q <= mem[rd_addr];

    if (take && item_i.is_query) begin
      qch_q   <= cix;
      walk_q  <= first_c;
      last_q  <= last_c;
      empty_q <= q_empty;
      mn_q    <= PEAK_POS;
      mx_q    <= CODE_MIN;
    end
    if (rd_en) walk_q <= walk_q + POS_W'(1);
    if (rd_valid_q) begin
      if (bmin < mn_q) mn_q <= bmin;
      if (bmax > mx_q) mx_q <= bmax;
    end
    if (state_q == ST_OUT && out_free) begin
      if (empty_q || (mn_q > mx_q)) begin
        out_data_o  <= '0;
        out_empty_o <= 1'b1;
      end else begin
        out_data_o  <= {mx_q, mn_q};
        out_empty_o <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for waveform_peak_builder_and_query
// Streams sample pushes and range queries into the block. A behavioral model
// of the per-channel running peaks and of the bucket store predicts every
// query result. A monitor compares each result transaction field by field.
// Several register settings and idle patterns are used, and one long
// receiver hold-off forces input backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import wpbq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUCKET = 256;
  localparam int NBUCKETS = 4096;
  localparam int NCHAN = 8;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic signed [SAMPLE_W-1:0] min_peak;
    logic signed [SAMPLE_W-1:0] max_peak;
    logic                       range_empty;
  } peak_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  // channel, sample_value, start_sample, end_sample from bit 0 up
  logic [TDATA_W-1:0] s_axis_tdata;
  // opcode
  logic               s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  // min_peak, max_peak from bit 0 up
  logic [ODATA_W-1:0] m_axis_tdata;
  // range_empty
  logic               m_axis_tuser;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [CFG_W-1:0]   cfg_data_i;

  waveform_peak_builder_and_query dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Peak model: registers, running pairs, positions and the written buckets.
  int                         model_channels;
  int                         model_total;
  logic signed [SAMPLE_W-1:0] run_lo [NCHAN];
  logic signed [SAMPLE_W-1:0] run_hi [NCHAN];
  int                         fill_pos [NCHAN];
  logic signed [SAMPLE_W-1:0] bucket_lo [int];
  logic signed [SAMPLE_W-1:0] bucket_hi [int];

  peak_result_t pending_peaks[$];

  int errors;
  int pushes_sent;
  int queries_sent;
  int results_seen;
  int send_idle_pct;
  int recv_idle_pct;
  bit recv_hold;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Fold one accepted sample into the model.
  function automatic void fold_sample(int ch, logic signed [SAMPLE_W-1:0] code);
    int pos;
    if (ch >= model_channels) return;
    pos = fill_pos[ch];
    if (pos >= model_total) return;
    // full-scale negative code saturates to the symmetric limit
    if (code == CODE_MIN) code = PEAK_NEG;
    if (code < run_lo[ch]) run_lo[ch] = code;
    if (code > run_hi[ch]) run_hi[ch] = code;
    fill_pos[ch] = pos + 1;
    if ((pos + 1) % BUCKET == 0 || pos + 1 == model_total) begin
      if (pos / BUCKET < NBUCKETS) begin
        bucket_lo[ch * NBUCKETS + pos / BUCKET] = run_lo[ch];
        bucket_hi[ch * NBUCKETS + pos / BUCKET] = run_hi[ch];
      end
      run_lo[ch] = PEAK_POS;
      run_hi[ch] = PEAK_NEG;
    end
  endfunction

  // Range min/max over the covered buckets; hole flags a never-written bucket.
  function automatic peak_result_t range_peaks(int ch, int s, int e, output bit hole);
    peak_result_t r;
    int first;
    int last;
    int nb;
    int lo;
    int hi;
    r.min_peak = '0;
    r.max_peak = '0;
    r.range_empty = 1'b1;
    hole = 1'b0;
    lo = 32767;
    hi = -32768;
    if (ch >= model_channels) return r;
    if (e > model_total) e = model_total;
    if (s > e) s = e;
    if (s >= e) return r;
    nb = (model_total + BUCKET - 1) / BUCKET;
    first = s / BUCKET;
    last = (e - 1) / BUCKET;
    if (last > nb - 1) last = nb - 1;
    if (last > NBUCKETS - 1) last = NBUCKETS - 1;
    if (first > last) return r;
    for (int b = first; b <= last; b++) begin
      if (!bucket_lo.exists(ch * NBUCKETS + b)) begin
        hole = 1'b1;
      end else begin
        if (bucket_lo[ch * NBUCKETS + b] < lo) lo = bucket_lo[ch * NBUCKETS + b];
        if (bucket_hi[ch * NBUCKETS + b] > hi) hi = bucket_hi[ch * NBUCKETS + b];
      end
    end
    if (lo > hi) return r;
    r.min_peak = lo[SAMPLE_W-1:0];
    r.max_peak = hi[SAMPLE_W-1:0];
    r.range_empty = 1'b0;
    return r;
  endfunction

  // Offer one transaction; predict on acceptance. tvalid stays high between
  // back-to-back items and drops only for an idle gap.
  task automatic send_item(opcode_e op, int ch, logic signed [SAMPLE_W-1:0] code,
                           logic [POS_W-1:0] s, logic [POS_W-1:0] e);
    peak_result_t r;
    bit hole;
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, e, s, code, ch[CH_W-1:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_PUSH) begin
      fold_sample(ch, code);
      pushes_sent++;
    end else begin
      r = range_peaks(ch, s, e, hole);
      pending_peaks.push_back(r);
      queries_sent++;
    end
  endtask

  // Drain everything, let the pipeline settle, then write one register.
  task automatic write_reg(cfg_reg_e idx, int value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_peaks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_NUM_CHANNELS) model_channels = value & 'hF;
    else model_total = value & 'h1FFFFF;
  endtask

  task automatic push_sample(int ch, int code);
    send_item(OP_PUSH, ch, code[SAMPLE_W-1:0], '0, '0);
  endtask

  task automatic query_range(int ch, int s, int e);
    send_item(OP_QUERY, ch, '0, s[POS_W-1:0], e[POS_W-1:0]);
  endtask

  // Pick a query that never walks an unwritten bucket. Mostly ranges inside
  // the built part of a channel; some with fully random fields. Fall back to
  // an empty range (start forced past end) when no safe range turns up.
  task automatic random_query();
    int ch;
    int s;
    int e;
    bit hole;
    peak_result_t r;
    ch = $urandom_range(0, NCHAN - 1);
    if ($urandom_range(0, 99) < 20) begin
      s = $urandom_range(0, 21'h1FFFFF);
      e = $urandom_range(0, 21'h1FFFFF);
      r = range_peaks(ch, s, e, hole);
    end else begin
      hole = 1'b1;
      for (int t = 0; t < 8 && hole; t++) begin
        e = $urandom_range(1, (fill_pos[ch] > 1) ? fill_pos[ch] : 1);
        s = $urandom_range(0, e);
        r = range_peaks(ch, s, e, hole);
      end
    end
    if (hole) s = 21'h1FFFFF;
    query_range(ch, s, e);
  endtask

  task automatic random_item();
    int k;
    if ($urandom_range(0, 99) < 35) begin
      random_query();
    end else begin
      k = $urandom_range(0, 99);
      if (k < 4) push_sample($urandom_range(0, 7), -32768);
      else if (k < 8) push_sample($urandom_range(0, 7), 32767);
      else if (k < 10) push_sample($urandom_range(0, 7), -32767);
      else push_sample($urandom_range(0, 7), $urandom_range(0, 16'hFFFF));
    end
  endtask

  // Extremes of the codes, bucket closed by the end of the source, pushes
  // past the end, invalid channels and every flavor of empty range.
  task automatic test_directed();
    write_reg(REG_NUM_CHANNELS, 8);
    write_reg(REG_TOTAL_SAMPLES, 5);
    push_sample(0, -32768);
    push_sample(0, 32767);
    push_sample(0, 100);
    push_sample(0, -5);
    push_sample(0, 7);
    push_sample(0, 9);
    push_sample(7, 32767);
    push_sample(7, 0);
    push_sample(7, -1);
    push_sample(7, 0);
    push_sample(7, 1);
    push_sample(3, -32768);
    query_range(0, 0, 5);
    query_range(0, 1, 2000000);
    query_range(0, 4, 4);
    query_range(0, 2097151, 3);
    query_range(7, 0, 5);
    query_range(7, 4, 5);
    write_reg(REG_NUM_CHANNELS, 2);
    push_sample(5, 1234);
    query_range(5, 0, 5);
    query_range(7, 0, 5);
    query_range(0, 0, 1);
  endtask

  task automatic test_random_phase(int nch, int total, int n_items);
    write_reg(REG_NUM_CHANNELS, nch);
    write_reg(REG_TOTAL_SAMPLES, total);
    repeat (n_items) random_item();
  endtask

  // Hold the receiver off while the sender keeps offering queries and pushes.
  task automatic test_backpressure();
    write_reg(REG_NUM_CHANNELS, 8);
    write_reg(REG_TOTAL_SAMPLES, 1048576);
    send_idle_pct = 0;
    recv_hold = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      repeat (60) begin
        if ($urandom_range(0, 1)) random_query();
        else random_item();
      end
    join
  endtask

  // Receiver readiness: random stalls, or a forced hold-off.
  always @(posedge clk_i) begin
    if (recv_hold) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    peak_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_peaks.size() == 0) begin
        $display("%0t: unexpected result min=%0d max=%0d empty=%0b", $time,
                 $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]), m_axis_tuser);
        errors++;
      end else begin
        exp_r = pending_peaks.pop_front();
        if ($signed(m_axis_tdata[15:0]) != exp_r.min_peak) begin
          $display("%0t: min_peak expected %0d actual %0d", $time, exp_r.min_peak,
                   $signed(m_axis_tdata[15:0]));
          errors++;
        end
        if ($signed(m_axis_tdata[31:16]) != exp_r.max_peak) begin
          $display("%0t: max_peak expected %0d actual %0d", $time, exp_r.max_peak,
                   $signed(m_axis_tdata[31:16]));
          errors++;
        end
        if (m_axis_tuser != exp_r.range_empty) begin
          $display("%0t: range_empty expected %0b actual %0b", $time, exp_r.range_empty,
                   m_axis_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    errors = 0;
    pushes_sent = 0;
    queries_sent = 0;
    results_seen = 0;
    recv_hold = 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 72;
    model_channels = NCH_RESET;
    model_total = TOTAL_RESET;
    for (int c = 0; c < NCHAN; c++) begin
      run_lo[c] = PEAK_POS;
      run_hi[c] = PEAK_NEG;
      fill_pos[c] = 0;
    end
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = 1'b0;
    cfg_data_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_phase(8, 1048576, 300);
    test_random_phase(1, 600, 250);
    send_idle_pct = 72;
    recv_idle_pct = 34;
    test_random_phase(4, 1000, 300);
    test_random_phase(2, 1, 100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_phase(5, 1048576, 300);
    test_backpressure();

    s_axis_tvalid <= 1'b0;
    while (pending_peaks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d pushes and %0d queries, %0d results checked", pushes_sent,
             queries_sent, results_seen);
    $display("register settings: 1..8 channels, 1..1048576 samples, with backpressure");
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
